// ----- rtl/pose_follower_with_snap_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef POSE_FOLLOWER_WITH_SNAP_ASSERT_SVH
`define POSE_FOLLOWER_WITH_SNAP_ASSERT_SVH

// Same-cycle implication.
`define PFS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pfs assertion failed");

// Next-cycle implication.
`define PFS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pfs assertion failed");

`endif

// ----- rtl/pfs_pkg.sv -----
package pfs_pkg;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic [15:0]        d;
		logic [15:0]        e;
		logic [15:0]        f;
		logic               done;
	} pose_t;

	localparam logic               ACT_TICK       = 1'b0;
	localparam logic               ACT_LOAD       = 1'b1;

	localparam logic [7:0]         MODE_RETREAT_A = 8'd1;
	localparam logic [7:0]         MODE_RETREAT_B = 8'd8;

	localparam logic signed [31:0] SNAP_HI        = 32'sd127;
	localparam logic signed [31:0] SNAP_LO        = -32'sd128;
	localparam logic signed [16:0] ANG_NEAR       = 17'sd128;

	localparam logic signed [31:0] DECAY_MAX      = 32'sd32767;
	localparam logic signed [31:0] RETREAT_DROP   = 32'sd4096;
	localparam logic signed [31:0] PARK_B_MAX     = 32'sd63;
	localparam logic signed [15:0] ANG_STEP_MAX   = 16'sd31;
	localparam logic signed [15:0] ANG_END        = 16'sd32;

endpackage

// ----- rtl/pfs_pos_unit.sv -----
module pfs_pos_unit (
	input  logic signed [31:0] cur,
	input  logic signed [31:0] tgt,
	output logic signed [31:0] nxt
);
	import pfs_pkg::*;

	logic signed [31:0] gap;
	logic signed [31:0] gap_rnd;
	logic signed [31:0] nxt_raw;
	logic signed [31:0] diff;
	logic               snap;

	always_comb begin
		gap     = tgt - cur;
		gap_rnd = gap + $signed({30'd0, {2{gap[31]}}});
		nxt_raw = cur + (gap_rnd >>> 2);
		diff    = tgt - nxt_raw;
		snap    = ((tgt > nxt_raw) && (diff <= SNAP_HI)) ||
		          ((tgt < nxt_raw) && (diff > SNAP_LO));
		nxt     = snap ? tgt : nxt_raw;
	end

endmodule

// ----- rtl/pfs_ang_unit.sv -----
module pfs_ang_unit (
	input  logic [15:0] cur,
	input  logic [15:0] tgt,
	output logic [15:0] nxt
);
	import pfs_pkg::*;

	logic signed [16:0] diff;
	logic               up;

	always_comb begin
		diff = $signed({tgt[15], tgt}) - $signed({cur[15], cur});
		if (diff[16])
			up = (diff < -ANG_NEAR);
		else
			up = (diff <= ANG_NEAR);
		if (cur == tgt)
			nxt = cur;
		else
			nxt = up ? cur + 16'd1 : cur - 16'd1;
	end

endmodule

// ----- rtl/pfs_step.sv -----
module pfs_step (
	input  pfs_pkg::pose_t     st,
	input  logic               action,
	input  logic [7:0]         mode_code,
	input  logic signed [31:0] target_a,
	input  logic signed [31:0] target_b,
	input  logic signed [31:0] target_c,
	input  logic [15:0]        target_d,
	input  logic [15:0]        target_e,
	input  logic [15:0]        target_ang_f,
	output pfs_pkg::pose_t     nx
);
	import pfs_pkg::*;

	logic signed [31:0] fa, fb, fc;
	logic [15:0]        fd, fe, ff;
	logic signed [31:0] rb, rb_rnd;
	logic [15:0]        rd;
	logic               retreat;

	pfs_pos_unit u_pos_a (.cur(st.a), .tgt(target_a), .nxt(fa));
	pfs_pos_unit u_pos_b (.cur(st.b), .tgt(target_b), .nxt(fb));
	pfs_pos_unit u_pos_c (.cur(st.c), .tgt(target_c), .nxt(fc));
	pfs_ang_unit u_ang_d (.cur(st.d), .tgt(target_d), .nxt(fd));
	pfs_ang_unit u_ang_e (.cur(st.e), .tgt(target_e), .nxt(fe));
	pfs_ang_unit u_ang_f (.cur(st.f), .tgt(target_ang_f), .nxt(ff));

	always_comb begin
		retreat = (mode_code == MODE_RETREAT_A) || (mode_code == MODE_RETREAT_B);
		rb_rnd  = st.b + $signed({29'd0, {3{st.b[31]}}});
		rd      = st.d;
		if (st.b <= DECAY_MAX) begin
			rb = st.b - (rb_rnd >>> 3);
			if ($signed(st.d) <= ANG_STEP_MAX)
				rd = st.d + 16'd1;
		end else begin
			rb = st.b - RETREAT_DROP;
		end

		nx = st;
		priority if (action == ACT_LOAD) begin
			nx.a    = target_a;
			nx.b    = target_b;
			nx.c    = target_c;
			nx.d    = target_d;
			nx.e    = target_e;
			nx.f    = target_ang_f;
			nx.done = 1'b0;
		end else if (st.done) begin
			nx = st;
		end else if (retreat) begin
			nx.b = rb;
			nx.d = rd;
			if (($signed(rd) == ANG_END) && (rb <= PARK_B_MAX)) begin
				nx.b    = 32'sd0;
				nx.done = 1'b1;
			end
		end else begin
			nx.a    = fa;
			nx.b    = fb;
			nx.c    = fc;
			nx.d    = fd;
			nx.e    = fe;
			nx.f    = ff;
			nx.done = (fa == target_a) && (fb == target_b) && (fc == target_c) &&
			          (fd == target_d) && (fe == target_e) && (ff == target_ang_f);
		end
	end

endmodule

// ----- rtl/pose_follower_with_snap.sv -----
// Pose follower with snap.
// Input channel in_valid/in_ready carries one item: action (0 = tick, 1 = load the
// pose from the target fields), mode_code (1 or 8 = retreat, else approach) and
// the six target components. Output channel out_valid/out_ready returns one
// result per item: the pose and the arrived flag after that item.
// An accepted item is held in the input register, and its result is written
// to the pose register, which drives the outputs.
// Throughput: one item per cycle while out_ready stays high; the pose update
// is a single pass of adds, shifts and compares between the input register
// and the pose register, which doubles as the result register.
// Reset (arst_n low) clears the pose and the arrived flag to zero and empties
// both registers; no result is shown until an item comes in.
// When the receiver stalls the result holds, one more item may be taken into
// the input register, and then in_ready drops until the result is taken.
`include "pose_follower_with_snap_assert.svh"

module pose_follower_with_snap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [7:0]         mode_code,
	input  logic signed [31:0] target_a,
	input  logic signed [31:0] target_b,
	input  logic signed [31:0] target_c,
	input  logic [15:0]        target_d,
	input  logic [15:0]        target_e,
	input  logic [15:0]        target_ang_f,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] cur_a,
	output logic signed [31:0] cur_b,
	output logic signed [31:0] cur_c,
	output logic [15:0]        cur_d,
	output logic [15:0]        cur_e,
	output logic [15:0]        cur_f,
	output logic               arrived
);
	import pfs_pkg::*;

	logic               valid_s1;
	logic               action_s1;
	logic [7:0]         mode_s1;
	logic signed [31:0] tgt_a_s1, tgt_b_s1, tgt_c_s1;
	logic [15:0]        tgt_d_s1, tgt_e_s1, tgt_f_s1;
	pose_t              pose_q;
	pose_t              pose_nx;
	logic               out_valid_q;
	logic               advance;
	logic               take;
	logic               load_s1;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;
	assign load_s1  = (action_s1 == ACT_LOAD);

	pfs_step u_step (
		.st           (pose_q),
		.action       (action_s1),
		.mode_code    (mode_s1),
		.target_a     (tgt_a_s1),
		.target_b     (tgt_b_s1),
		.target_c     (tgt_c_s1),
		.target_d     (tgt_d_s1),
		.target_e     (tgt_e_s1),
		.target_ang_f (tgt_f_s1),
		.nx           (pose_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1 <= action;
			mode_s1   <= mode_code;
			tgt_a_s1  <= target_a;
			tgt_b_s1  <= target_b;
			tgt_c_s1  <= target_c;
			tgt_d_s1  <= target_d;
			tgt_e_s1  <= target_e;
			tgt_f_s1  <= target_ang_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			pose_q      <= pose_nx;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cur_a     = pose_q.a;
	assign cur_b     = pose_q.b;
	assign cur_c     = pose_q.c;
	assign cur_d     = pose_q.d;
	assign cur_e     = pose_q.e;
	assign cur_f     = pose_q.f;
	assign arrived   = pose_q.done;

	`PFS_ASSERT_NXT(a_load, clk, arst_n, advance && load_s1, !arrived && (cur_a == $past(tgt_a_s1)))
	`PFS_ASSERT_NXT(a_done_hold, clk, arst_n, advance && !load_s1 && arrived, pose_q == $past(pose_q))
	`PFS_ASSERT_NXT(a_result_shown, clk, arst_n, advance, out_valid)
	`PFS_ASSERT_NOW(a_stall_only, clk, arst_n, !in_ready, valid_s1 && out_valid && !out_ready)

endmodule

// ----- tb/pose_checker.sv -----
`timescale 1ns / 100ps

module pose_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic [7:0]         mode_code,
	input  logic signed [31:0] target_a,
	input  logic signed [31:0] target_b,
	input  logic signed [31:0] target_c,
	input  logic [15:0]        target_d,
	input  logic [15:0]        target_e,
	input  logic [15:0]        target_ang_f,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] cur_a,
	input  logic signed [31:0] cur_b,
	input  logic signed [31:0] cur_c,
	input  logic [15:0]        cur_d,
	input  logic [15:0]        cur_e,
	input  logic [15:0]        cur_f,
	input  logic               arrived,
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked,
	output int                 arrivals
);
	import pfs_pkg::*;

	pose_t held_pose;
	pose_t expected_poses[$];

	function automatic logic [31:0] pos_toward(logic [31:0] cur, logic [31:0] tgt);
		logic [31:0] gap;
		logic [31:0] nxt;
		logic [31:0] rest;
		gap = tgt - cur;
		if (gap[31])
			gap = gap + 32'd3;
		nxt = cur + {{2{gap[31]}}, gap[31:2]};
		rest = tgt - nxt;
		if (($signed(tgt) > $signed(nxt) && $signed(rest) <= SNAP_HI) ||
			($signed(tgt) < $signed(nxt) && $signed(rest) > SNAP_LO))
			nxt = tgt;
		return nxt;
	endfunction

	function automatic logic [15:0] ang_toward(logic [15:0] cur, logic [15:0] tgt);
		logic signed [16:0] span;
		logic up;
		span = $signed({tgt[15], tgt}) - $signed({cur[15], cur});
		if (span == 0)
			return cur;
		if (span > 0)
			up = (span <= ANG_NEAR);
		else
			up = (span < -ANG_NEAR);
		return up ? cur + 16'd1 : cur - 16'd1;
	endfunction

	function automatic pose_t pose_after(pose_t p, logic act, logic [7:0] mode,
			logic [31:0] ta, logic [31:0] tb, logic [31:0] tc,
			logic [15:0] td, logic [15:0] te, logic [15:0] tf);
		logic [31:0] rem;
		pose_t n;
		n = p;
		if (act == ACT_LOAD) begin
			n.a = ta;
			n.b = tb;
			n.c = tc;
			n.d = td;
			n.e = te;
			n.f = tf;
			n.done = 1'b0;
		end else if (!p.done) begin
			if (mode == MODE_RETREAT_A || mode == MODE_RETREAT_B) begin
				if ($signed(n.b) <= DECAY_MAX) begin
					rem = n.b;
					if (rem[31])
						rem = rem + 32'd7;
					n.b = n.b - {{3{rem[31]}}, rem[31:3]};
					if ($signed(n.d) <= ANG_STEP_MAX)
						n.d = n.d + 16'd1;
				end else
					n.b = n.b - RETREAT_DROP;
				if ($signed(n.d) == ANG_END && $signed(n.b) <= PARK_B_MAX) begin
					n.b = '0;
					n.done = 1'b1;
				end
			end else begin
				n.a = pos_toward(p.a, ta);
				n.b = pos_toward(p.b, tb);
				n.c = pos_toward(p.c, tc);
				n.d = ang_toward(p.d, td);
				n.e = ang_toward(p.e, te);
				n.f = ang_toward(p.f, tf);
				n.done = (n.a == ta) && (n.b == tb) && (n.c == tc) &&
					(n.d == td) && (n.e == te) && (n.f == tf);
			end
		end
		return n;
	endfunction

	function automatic int field_mismatch(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		int errs;
		if (!arst_n) begin
			held_pose = '0;
			expected_poses.delete();
			fail_count <= 0;
			outstanding <= 0;
			results_checked <= 0;
			arrivals <= 0;
		end else begin
			errs = 0;
			if (out_valid && out_ready) begin
				if (expected_poses.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h %h %h %h %h %b",
						$time, cur_a, cur_b, cur_c, cur_d, cur_e, cur_f, arrived);
					errs = 1;
				end else begin
					want = expected_poses.pop_front();
					errs += field_mismatch("cur_a", want.a, cur_a);
					errs += field_mismatch("cur_b", want.b, cur_b);
					errs += field_mismatch("cur_c", want.c, cur_c);
					errs += field_mismatch("cur_d", {16'd0, want.d}, {16'd0, cur_d});
					errs += field_mismatch("cur_e", {16'd0, want.e}, {16'd0, cur_e});
					errs += field_mismatch("cur_f", {16'd0, want.f}, {16'd0, cur_f});
					errs += field_mismatch("arrived", {31'd0, want.done}, {31'd0, arrived});
				end
				results_checked <= results_checked + 1;
				arrivals <= arrivals + (arrived === 1'b1);
			end
			if (in_valid && in_ready) begin
				held_pose = pose_after(held_pose, action, mode_code, target_a, target_b,
					target_c, target_d, target_e, target_ang_f);
				expected_poses.push_back(held_pose);
			end
			fail_count <= fail_count + errs;
			outstanding <= expected_poses.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import pfs_pkg::*;

	localparam int   RANDOM_ITEMS = 1000;
	localparam int   CALM_ITEMS   = 150;
	localparam int   LONG_HOLD    = 300;
	localparam int   CYCLE_LIMIT  = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACT_TICK;
	logic [7:0]         mode_code = '0;
	logic signed [31:0] target_a = '0;
	logic signed [31:0] target_b = '0;
	logic signed [31:0] target_c = '0;
	logic [15:0]        target_d = '0;
	logic [15:0]        target_e = '0;
	logic [15:0]        target_ang_f = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] cur_a;
	logic signed [31:0] cur_b;
	logic signed [31:0] cur_c;
	logic [15:0]        cur_d;
	logic [15:0]        cur_e;
	logic [15:0]        cur_f;
	logic               arrived;

	int fail_count;
	int outstanding;
	int results_checked;
	int arrivals;

	bit calm;
	bit squeeze;
	int idle_pct;
	int sent;
	int load_count;
	int approach_count;
	int retreat_count;

	pose_follower_with_snap dut (.*);

	pose_checker chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] wide_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] near_value(logic [31:0] base);
		logic [31:0] mask;
		mask = (32'd1 << $urandom_range(0, 31)) - 32'd1;
		if ($urandom_range(0, 3) == 0)
			return wide_value();
		return base + ($urandom & mask) - (mask >> 1);
	endfunction

	function automatic logic [15:0] angle_near(logic [15:0] base);
		int span;
		span = ($urandom_range(0, 3) == 0) ? 160 : 40;
		return 16'(base + $urandom_range(0, 2 * span) - span);
	endfunction

	function automatic logic [7:0] approach_mode();
		logic [7:0] m;
		do
			m = 8'($urandom_range(0, 255));
		while (m == MODE_RETREAT_A || m == MODE_RETREAT_B);
		return m;
	endfunction

	function automatic logic [7:0] retreat_mode();
		return $urandom_range(0, 1) ? MODE_RETREAT_A : MODE_RETREAT_B;
	endfunction

	task automatic offer(logic act, logic [7:0] mode,
			logic [31:0] ta, logic [31:0] tb, logic [31:0] tc,
			logic [15:0] td, logic [15:0] te, logic [15:0] tf);
		in_valid <= 1'b1;
		action <= act;
		mode_code <= mode;
		target_a <= ta;
		target_b <= tb;
		target_c <= tc;
		target_d <= td;
		target_e <= te;
		target_ang_f <= tf;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		if (act == ACT_LOAD)
			load_count++;
		else if (mode == MODE_RETREAT_A || mode == MODE_RETREAT_B)
			retreat_count++;
		else
			approach_count++;
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic load_pose(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [15:0] d, logic [15:0] e, logic [15:0] f);
		offer(ACT_LOAD, 8'($urandom_range(0, 255)), a, b, c, d, e, f);
	endtask

	task automatic follow_target(int n, logic [31:0] ta, logic [31:0] tb, logic [31:0] tc,
			logic [15:0] td, logic [15:0] te, logic [15:0] tf);
		repeat (n) offer(ACT_TICK, approach_mode(), ta, tb, tc, td, te, tf);
	endtask

	task automatic retreat_steps(int n);
		repeat (n) offer(ACT_TICK, retreat_mode(), $urandom, $urandom, $urandom,
			16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				squeeze = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timed out after %0d cycles", cycles);
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [31:0] ba, bb, bc, ta, tb, tc;
		logic [15:0] bd, be, bf, td, te, tf;
		int end_mark;
		int squeeze_mark;
		bit squeezed;
		squeezed = 1'b0;
		idle_pct = 20;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pose already sits on an all-zero target
		offer(ACT_TICK, MODE_RETREAT_A - 8'd1, '0, '0, '0, '0, '0, '0);
		// hold while done, in both modes
		offer(ACT_TICK, 8'hFF, 32'd5, 32'd6, 32'd7, 16'd8, 16'd9, 16'd10);
		retreat_steps(1);
		// load while done, field extremes
		load_pose(32'h7FFF_FFFF, 32'h8000_0000, '0, 16'hFFFF, 16'h8000, 16'h7FFF);
		// wrapped position gaps snap, angles wrap at 16 bits, negative gap rounds
		offer(ACT_TICK, MODE_RETREAT_A + 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1000,
			16'h0000, 16'h7FFF, 16'h8000);
		offer(ACT_TICK, MODE_RETREAT_B + 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1000,
			16'h0000, 16'h7FFF, 16'h8000);
		offer(ACT_TICK, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1000,
			16'h0000, 16'h7FFF, 16'h8000);
		follow_target(2, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd1000,
			16'h0000, 16'h7FFF, 16'h8000);
		// snap window edges and angle distances around 128
		load_pose('0, '0, '0, '0, '0, '0);
		offer(ACT_TICK, MODE_RETREAT_A - 8'd1, 32'd127, 32'd600, -32'sd128,
			16'd128, 16'd129, 16'hFF80);
		follow_target(2, 32'd127, 32'd600, -32'sd128, 16'd127, 16'hFF7F, 16'h0000);
		// retreat: decay at the limit, drop above it, park, hold, min position
		load_pose($urandom, 32'h0000_7FFF, $urandom, '0, 16'($urandom), 16'($urandom));
		offer(ACT_TICK, MODE_RETREAT_A, '0, '0, '0, '0, '0, '0);
		load_pose($urandom, 32'h0000_8000, $urandom, 16'h001F, 16'($urandom),
			16'($urandom));
		offer(ACT_TICK, MODE_RETREAT_B, '0, '0, '0, '0, '0, '0);
		load_pose($urandom, 32'd100, $urandom, 16'd30, 16'($urandom), 16'($urandom));
		retreat_steps(5);
		load_pose($urandom, 32'h8000_0000, $urandom, 16'd32, 16'($urandom), 16'($urandom));
		retreat_steps(1);

		end_mark = sent + RANDOM_ITEMS;
		squeeze_mark = sent + 400;
		while (sent < end_mark) begin
			if (sent >= end_mark - CALM_ITEMS)
				calm = 1'b1;
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			if (!squeezed && sent >= squeeze_mark) begin
				squeezed = 1'b1;
				squeeze = 1'b1;
				idle_pct = 0;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					ba = wide_value();
					bb = wide_value();
					bc = wide_value();
					bd = 16'($urandom);
					be = 16'($urandom);
					bf = 16'($urandom);
					ta = near_value(ba);
					tb = near_value(bb);
					tc = near_value(bc);
					td = angle_near(bd);
					te = angle_near(be);
					tf = angle_near(bf);
					load_pose(ba, bb, bc, bd, be, bf);
					follow_target($urandom_range(4, 60), ta, tb, tc, td, te, tf);
				end
				5, 6, 7: begin
					case ($urandom_range(0, 3))
						0: bb = $urandom_range(0, 2000) - 1000;
						1: bb = $urandom_range(30000, 40000);
						2: bb = $urandom_range(0, 100000);
						default: bb = wide_value();
					endcase
					bd = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32));
					load_pose($urandom, bb, $urandom, bd, 16'($urandom), 16'($urandom));
					retreat_steps($urandom_range(8, 60));
				end
				default: begin
					repeat ($urandom_range(3, 15))
						offer(($urandom_range(0, 3) == 0) ? ACT_LOAD : ACT_TICK,
							8'($urandom_range(0, 255)), $urandom, $urandom, $urandom,
							16'($urandom), 16'($urandom), 16'($urandom));
				end
			endcase
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d items: %0d loads, %0d approach ticks, %0d retreat ticks",
			sent, load_count, approach_count, retreat_count);
		$display("checked %0d results, %0d with arrived set, across one long output stall",
			results_checked, arrivals);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pfs_pkg.sv
rtl/pfs_pos_unit.sv
rtl/pfs_ang_unit.sv
rtl/pfs_step.sv
rtl/pose_follower_with_snap.sv
tb/pose_checker.sv
tb/testbench.sv
